[sv/fslru_pkg.sv]
package fslru_pkg;

	// Field widths of one input word and one result word
	localparam int SLOT_W  = 6;
	localparam int FRAME_W = 32;

	// Default number of slots
	localparam int NUM_SLOTS_DEF = 64;

	// Action codes
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_TOUCH = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic clr_step;    // write zero at the sweep address, advance
		logic touch_wr;    // record frame number of a touched slot
		logic pop;         // pop the free stack, present the slot
		logic scan_init;   // rewind the scan address
		logic scan_rd;     // read one frame entry, advance
		logic emit_evict;  // present the least recently used slot
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic empty;       // free stack holds no slot
		logic addr_last;   // sweep/scan address is at the last slot
	} sts_t;

endpackage

[sv/free_stack_lru_slot_allocator.sv]
// Allocate from the free stack: done in the cycle after start; busy stays low, one word a cycle.
// Allocate with an empty stack: busy goes high through the scan, drain and emit states, and done follows emit,
// the scan reading the frame table one slot per cycle through its single read port.
// Touch: no result, busy stays low. Next start is taken in the cycle that done is strobed.
// Reset (arst_n low, asynchronous): stack full, then a sweep over every slot zeroes the frame
// table with busy high. Results are strobed on done for one cycle; the receiver cannot stall.
module free_stack_lru_slot_allocator #(
	parameter int NUM_SLOTS = fslru_pkg::NUM_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           action,
	input  logic [fslru_pkg::SLOT_W-1:0]   slot_index,
	input  logic [fslru_pkg::FRAME_W-1:0]  frame_number,
	output logic                           done,
	output logic [fslru_pkg::SLOT_W-1:0]   granted_slot,
	output logic                           was_evicted
);

	fslru_pkg::cmd_t cmd;
	fslru_pkg::sts_t sts;

	fslru_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	fslru_dp #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.slot_index   (slot_index),
		.frame_number (frame_number),
		.sts          (sts),
		.done         (done),
		.granted_slot (granted_slot),
		.was_evicted  (was_evicted)
	);

`ifndef SYNTHESIS
	// Results appear only once the controller is back in idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while busy");

	// Pop from a non-empty stack answers in the next cycle
	a_pop_next: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action == fslru_pkg::ACT_ALLOC && !sts.empty)
		|=> (done && !was_evicted))
		else $error("stack pop did not answer next cycle");

	// A touch produces no result
	a_touch_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action == fslru_pkg::ACT_TOUCH) |=> !done)
		else $error("touch produced a result");
`endif

endmodule

[sv/fslru_ctrl.sv]
module fslru_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              action,
	input  fslru_pkg::sts_t   sts,
	output fslru_pkg::cmd_t   cmd,
	output logic              busy
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Decode next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.addr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					if (action == fslru_pkg::ACT_TOUCH) begin
						cmd.touch_wr = 1'b1;
					end else if (!sts.empty) begin
						cmd.pop = 1'b1;
					end else begin
						cmd.scan_init = 1'b1;
						state_d       = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.addr_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit_evict = 1'b1;
				state_d        = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state; start with the clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

[sv/fslru_dp.sv]
module fslru_dp #(
	parameter int NUM_SLOTS = fslru_pkg::NUM_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fslru_pkg::cmd_t                cmd,
	input  logic [fslru_pkg::SLOT_W-1:0]   slot_index,
	input  logic [fslru_pkg::FRAME_W-1:0]  frame_number,
	output fslru_pkg::sts_t                sts,
	output logic                           done,
	output logic [fslru_pkg::SLOT_W-1:0]   granted_slot,
	output logic                           was_evicted
);

	localparam int IDX_W  = $clog2(NUM_SLOTS);
	localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
	localparam int WIDE_W = (CNT_W > fslru_pkg::SLOT_W) ? CNT_W : fslru_pkg::SLOT_W;

	// Frame table and scan state
	logic [fslru_pkg::FRAME_W-1:0] frame_mem [NUM_SLOTS];
	logic [fslru_pkg::FRAME_W-1:0] rd_data_q;
	logic [fslru_pkg::FRAME_W-1:0] best_frame_q;
	logic [IDX_W-1:0]              best_idx_q;
	logic [IDX_W-1:0]              addr_q;
	logic [IDX_W-1:0]              rd_idx_s1;
	logic                          rd_v_s1;
	logic [CNT_W-1:0]              count_q;
	logic [CNT_W-1:0]              count_m1;
	logic                          done_q;
	logic [fslru_pkg::SLOT_W-1:0]  granted_q;
	logic                          evicted_q;

	// Write port selection
	logic [WIDE_W-1:0]             slot_wide;
	logic                          slot_ok;
	logic                          wr_en;
	logic [IDX_W-1:0]              wr_addr;
	logic [fslru_pkg::FRAME_W-1:0] wr_data;
	logic [WIDE_W-1:0]             pop_wide;
	logic [WIDE_W-1:0]             best_wide;

	assign slot_wide = WIDE_W'(slot_index);
	assign slot_ok   = (32'(slot_index) < 32'(NUM_SLOTS));
	assign wr_en     = cmd.clr_step || (cmd.touch_wr && slot_ok);
	assign wr_addr   = cmd.clr_step ? addr_q : slot_wide[IDX_W-1:0];
	assign wr_data   = cmd.clr_step ? '0 : frame_number;

	// Free stack entry k holds k and nothing is pushed back, so the top is count - 1
	assign count_m1  = count_q - CNT_W'(1);
	assign pop_wide  = WIDE_W'(count_m1);
	assign best_wide = WIDE_W'(best_idx_q);

	assign sts.empty     = (count_q == '0);
	assign sts.addr_last = (addr_q == IDX_W'(NUM_SLOTS - 1));

	// Write and read the frame table
	always_ff @(posedge clk) begin
		if (wr_en) begin
			frame_mem[wr_addr] <= wr_data;
		end
		if (cmd.scan_rd) begin
			rd_data_q <= frame_mem[addr_q];
		end
	end

	// Advance sweep/scan address, track read pipeline and stack count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			rd_v_s1 <= 1'b0;
			count_q <= CNT_W'(NUM_SLOTS);
			done_q  <= 1'b0;
		end else begin
			if (cmd.scan_init) begin
				addr_q <= '0;
			end else if (cmd.clr_step || cmd.scan_rd) begin
				addr_q <= addr_q + IDX_W'(1);
			end
			rd_v_s1 <= cmd.scan_rd;
			if (cmd.pop) begin
				count_q <= count_m1;
			end
			done_q <= cmd.pop || cmd.emit_evict;
		end
	end

	// Keep the smallest frame; strict compare keeps the lowest index on ties
	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q;
		if (rd_v_s1 && (rd_idx_s1 == '0 || rd_data_q < best_frame_q)) begin
			best_frame_q <= rd_data_q;
			best_idx_q   <= rd_idx_s1;
		end
	end

	// Load the result word
	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			granted_q <= pop_wide[fslru_pkg::SLOT_W-1:0];
			evicted_q <= 1'b0;
		end else if (cmd.emit_evict) begin
			granted_q <= best_wide[fslru_pkg::SLOT_W-1:0];
			evicted_q <= 1'b1;
		end
	end

	assign done         = done_q;
	assign granted_slot = granted_q;
	assign was_evicted  = evicted_q;

endmodule
